// ===== rtl/core/scfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksummed frame deframer: shared definitions
// Widths and defaults used by the deframer queue, engine and top level.
// ----------------------------------------------------------------------------
package scfd_pkg;

    localparam int BYTE_W          = 8;
    localparam int PLEN_W          = 6;

    // A frame is head, length, payload and sum, so the length is payload + 3.
    localparam int MIN_FRAME       = 4;
    localparam int FRAME_OVERHEAD  = 3;

    localparam int MAX_FRAME_DEF   = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

endpackage

// ===== rtl/core/scfd_chan_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksummed frame deframer: channel interfaces
// Valid/ready channels for received bytes and for payload results.
// ----------------------------------------------------------------------------
interface scfd_in_if;
    logic                        valid;
    logic                        ready;
    logic [scfd_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface scfd_out_if;
    logic                        valid;
    logic                        ready;
    logic [scfd_pkg::BYTE_W-1:0] payload_byte;
    logic                        last;
    logic [scfd_pkg::PLEN_W-1:0] payload_length;

    modport source (output valid, output payload_byte, output last,
                    output payload_length, input ready);
    modport sink   (input valid, input payload_byte, input last,
                    input payload_length, output ready);
endinterface

// ===== rtl/core/scfd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksummed frame deframer: input queue
// Small FIFO that takes received bytes while the engine is busy scanning.
// ----------------------------------------------------------------------------
module scfd_queue #(
    parameter int DEPTH = scfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    scfd_in_if.sink       i_in,
    scfd_in_if.source     o_q
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [scfd_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]               r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]               r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]               r_count,  n_count;
    logic                        push, pop;

    assign i_in.ready  = (r_count != CW'(DEPTH));
    assign o_q.valid   = (r_count != '0);
    assign o_q.in_byte = r_mem[r_rd_ptr];

    assign push = i_in.valid && i_in.ready;
    assign pop  = o_q.valid && o_q.ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_in.in_byte;
        end
    end

endmodule

// ===== rtl/core/scfd_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksummed frame deframer: scan engine
// Keeps the candidate window in a circular buffer, checks head, length and
// sum from the oldest byte, and streams out the payload of a good frame.
// ----------------------------------------------------------------------------
module scfd_engine #(
    parameter int MAX_FRAME = scfd_pkg::MAX_FRAME_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [scfd_pkg::BYTE_W-1:0] i_cfg_wdata,
    scfd_in_if.sink                     i_in,
    scfd_out_if.source                  o_out
);

    localparam int AW = $clog2(MAX_FRAME);
    localparam int DEPTH = 1 << AW;
    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam int BW = scfd_pkg::BYTE_W;
    localparam int PW = scfd_pkg::PLEN_W;
    localparam logic [BW-1:0] MAX_LEN = BW'(MAX_FRAME);
    localparam logic [BW-1:0] MIN_LEN = BW'(scfd_pkg::MIN_FRAME);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_HEAD = 6'b000010,
        S_HCHK = 6'b000100,
        S_LCHK = 6'b001000,
        S_SUM  = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_base,  n_base;
    logic [CW-1:0]   r_fill,  n_fill;
    logic [CW-1:0]   r_len,   n_len;
    logic [CW-1:0]   r_idx,   n_idx;
    logic [BW-1:0]   r_sum,   n_sum;
    logic [BW-1:0]   r_head_byte;

    logic [BW-1:0]   r_win [DEPTH];
    logic [BW-1:0]   r_rdata;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;

    logic            r_out_valid, n_out_valid;
    logic [BW-1:0]   r_out_byte,  n_out_byte;
    logic            r_out_last,  n_out_last;
    logic [PW-1:0]   r_out_plen,  n_out_plen;
    logic            out_free;

    assign out_free             = !r_out_valid || o_out.ready;
    assign o_out.valid          = r_out_valid;
    assign o_out.payload_byte   = r_out_byte;
    assign o_out.last           = r_out_last;
    assign o_out.payload_length = r_out_plen;
    assign i_in.ready           = (r_state == S_IDLE);

    // The newest byte always lands right after the window; when the window is
    // full the base moves on instead of the fill, dropping the oldest byte.
    assign wr_addr = r_base + r_fill[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_fill      = r_fill;
        n_len       = r_len;
        n_idx       = r_idx;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_plen  = r_out_plen;
        rd_en       = 1'b0;
        rd_addr     = r_base;
        wr_en       = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    wr_en = 1'b1;
                    if (r_fill == CW'(MAX_FRAME)) begin
                        n_base = r_base + AW'(1);
                    end else begin
                        n_fill = r_fill + CW'(1);
                    end
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                if (r_fill == '0) begin
                    n_state = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_base;
                    n_state = S_HCHK;
                end
            end
            S_HCHK: begin
                if (r_rdata != r_head_byte) begin
                    n_base  = r_base + AW'(1);
                    n_fill  = r_fill - CW'(1);
                    n_state = S_HEAD;
                end else if (r_fill < CW'(2)) begin
                    n_state = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_base + AW'(1);
                    n_state = S_LCHK;
                end
            end
            S_LCHK: begin
                if (r_rdata < MIN_LEN || r_rdata > MAX_LEN) begin
                    n_base  = r_base + AW'(1);
                    n_fill  = r_fill - CW'(1);
                    n_state = S_HEAD;
                end else if (r_fill < CW'(r_rdata)) begin
                    // Candidate not complete yet: wait for more bytes.
                    n_state = S_IDLE;
                end else begin
                    n_len   = CW'(r_rdata);
                    n_idx   = CW'(1);
                    n_sum   = '0;
                    rd_en   = 1'b1;
                    rd_addr = r_base;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                // The read data holds window byte r_idx - 1.
                if (r_idx == r_len) begin
                    if (r_sum == r_rdata) begin
                        n_idx   = CW'(3);
                        rd_en   = 1'b1;
                        rd_addr = r_base + AW'(2);
                        n_state = S_EMIT;
                    end else begin
                        n_base  = r_base + AW'(1);
                        n_fill  = r_fill - CW'(1);
                        n_state = S_HEAD;
                    end
                end else begin
                    n_sum   = r_sum + r_rdata;
                    n_idx   = r_idx + CW'(1);
                    rd_en   = 1'b1;
                    rd_addr = r_base + r_idx[AW-1:0];
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_rdata;
                    n_out_last  = (r_idx == r_len - CW'(1));
                    n_out_plen  = PW'(r_len - CW'(scfd_pkg::FRAME_OVERHEAD));
                    if (r_idx == r_len - CW'(1)) begin
                        n_base  = r_base + r_len[AW-1:0];
                        n_fill  = r_fill - r_len;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        rd_en   = 1'b1;
                        rd_addr = r_base + r_idx[AW-1:0];
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_head_byte <= '0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_head_byte <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_idx      <= n_idx;
        r_sum      <= n_sum;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_plen <= n_out_plen;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_win[wr_addr] <= i_in.in_byte;
        end
        if (rd_en) begin
            r_rdata <= r_win[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(MAX_FRAME))
        else $error("window fill exceeds the frame limit");

    a_emit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result beat loaded outside the emit state");

    a_sum_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> (r_idx <= r_len && r_len <= r_fill))
        else $error("sum index runs past the candidate frame");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free && r_idx == r_len - CW'(1))
        |=> (r_state == S_IDLE && r_out_valid && r_out_last))
        else $error("final payload beat did not close the frame");
`endif

endmodule

// ===== rtl/core/sum_checked_frame_deframer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksummed frame deframer: top level
// Finds head/length/payload/sum frames in a byte stream and emits payloads.
//
//   Channel  Dir  Handshake    Beat contents
//   i_in     in   valid/ready  in_byte
//   o_out    out  valid/ready  payload_byte, last, payload_length
//   i_cfg    in   write enable frame head byte
//
// A byte that leaves a candidate waiting passes the head check and, once the
// length is in, the length check. A rejected start is dropped at the head,
// length or sum check; the sum check reads the whole candidate from the window.
// A good frame then gives one payload beat per cycle unless o_out stalls.
// The input queue keeps taking bytes while the engine scans or emits, until full.
// Reset is synchronous and clears control state only; no clearing pass.
// ----------------------------------------------------------------------------
module sum_checked_frame_deframer_top #(
    parameter int MAX_FRAME   = scfd_pkg::MAX_FRAME_DEF,
    parameter int QUEUE_DEPTH = scfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [scfd_pkg::BYTE_W-1:0] i_cfg_wdata,
    scfd_in_if.sink                     i_in,
    scfd_out_if.source                  o_out
);

    scfd_in_if q_if ();

    scfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_q     (q_if.source)
    );

    scfd_engine #(
        .MAX_FRAME (MAX_FRAME)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (q_if.sink),
        .o_out       (o_out)
    );

endmodule

// ===== dv/sum_checked_frame_deframer_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksummed frame deframer: self-checking testbench
// Pushes byte streams through the deframer and compares every payload beat
// against a local model of the window scan. Streams mix good frames of all
// sizes with noise, bad sums, bad lengths and cut frames. Both sides of the
// block see random gaps and stalls, including one long output hold-off.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [scfd_pkg::BYTE_W-1:0] payload_byte;
    logic                        last;
    logic [scfd_pkg::PLEN_W-1:0] payload_length;
} t_payload_beat;

typedef enum {FLAW_NONE, FLAW_BAD_SUM, FLAW_BAD_LENGTH, FLAW_CUT} t_frame_flaw;

typedef enum {READY_ALWAYS, READY_HALF, READY_SPARSE} t_ready_mode;

class payload_predictor;
    logic [scfd_pkg::BYTE_W-1:0] head_byte;
    logic [scfd_pkg::BYTE_W-1:0] window_q [scfd_pkg::MAX_FRAME_DEF];
    int unsigned                 window_len;
    t_payload_beat               expected_beats [$];
    int unsigned                 error_count;
    int unsigned                 bytes_taken;
    int unsigned                 beats_checked;
    int unsigned                 frames_found;
    int unsigned                 longest_payload;

    function new();
        head_byte       = '0;
        window_len      = 0;
        error_count     = 0;
        bytes_taken     = 0;
        beats_checked   = 0;
        frames_found    = 0;
        longest_payload = 0;
    endfunction

    function void drop_oldest(int unsigned n);
        int unsigned k;
        if (n >= window_len) begin
            window_len = 0;
            return;
        end
        for (k = 0; k + n < window_len; k++) begin
            window_q[k] = window_q[k + n];
        end
        window_len -= n;
    endfunction

    // Appends one received byte and rescans the window from its oldest byte.
    function void take_byte(logic [scfd_pkg::BYTE_W-1:0] value);
        int unsigned                 frame_len;
        int unsigned                 plen;
        int unsigned                 k;
        logic [scfd_pkg::BYTE_W-1:0] sum;
        t_payload_beat               beat;
        bytes_taken++;
        if (window_len >= scfd_pkg::MAX_FRAME_DEF) begin
            drop_oldest(1);
        end
        window_q[window_len] = value;
        window_len++;
        while (window_len > 0) begin
            if (window_q[0] != head_byte) begin
                drop_oldest(1);
                continue;
            end
            if (window_len < 2) begin
                return;
            end
            frame_len = window_q[1];
            if (frame_len < scfd_pkg::MIN_FRAME ||
                frame_len > scfd_pkg::MAX_FRAME_DEF) begin
                drop_oldest(1);
                continue;
            end
            // An incomplete candidate simply waits for more bytes.
            if (window_len < frame_len) begin
                return;
            end
            sum = '0;
            for (k = 0; k + 1 < frame_len; k++) begin
                sum += window_q[k];
            end
            if (sum != window_q[frame_len - 1]) begin
                drop_oldest(1);
                continue;
            end
            plen = frame_len - scfd_pkg::FRAME_OVERHEAD;
            for (k = 0; k < plen; k++) begin
                beat.payload_byte   = window_q[2 + k];
                beat.last           = (k + 1 == plen);
                beat.payload_length = scfd_pkg::PLEN_W'(plen);
                expected_beats.push_back(beat);
            end
            frames_found++;
            if (plen > longest_payload) begin
                longest_payload = plen;
            end
            drop_oldest(frame_len);
            return;
        end
    endfunction

    function void check_beat(logic [scfd_pkg::BYTE_W-1:0] payload_byte, logic last,
                             logic [scfd_pkg::PLEN_W-1:0] payload_length);
        t_payload_beat want;
        if (expected_beats.size() == 0) begin
            $error("unexpected beat: payload_byte 0x%02h last %0d payload_length %0d",
                   payload_byte, last, payload_length);
            error_count++;
            return;
        end
        want = expected_beats.pop_front();
        beats_checked++;
        if (payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected 0x%02h, actual 0x%02h",
                   want.payload_byte, payload_byte);
            error_count++;
        end
        if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            error_count++;
        end
        if (payload_length !== want.payload_length) begin
            $error("payload_length: expected %0d, actual %0d",
                   want.payload_length, payload_length);
            error_count++;
        end
    endfunction
endclass

module sum_checked_frame_deframer_top_test;

    localparam int SETTLE_CYCLES = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 60;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [scfd_pkg::BYTE_W-1:0] i_cfg_wdata;

    scfd_in_if  in_ch ();
    scfd_out_if out_ch ();

    payload_predictor            board;
    logic [scfd_pkg::BYTE_W-1:0] stream_q [$];
    int unsigned                 burst_left;
    int unsigned                 heads_written;
    logic                        hold_req;

    sum_checked_frame_deframer_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("sum_checked_frame_deframer_top: mismatch");
        $finish;
    end

    // Builds one frame for the given head, optionally damaged.
    function automatic void append_frame(logic [scfd_pkg::BYTE_W-1:0] head,
                                         int unsigned plen, t_frame_flaw flaw);
        logic [scfd_pkg::BYTE_W-1:0] len_byte;
        logic [scfd_pkg::BYTE_W-1:0] sum;
        logic [scfd_pkg::BYTE_W-1:0] value;
        int unsigned                 k;
        len_byte = scfd_pkg::BYTE_W'(plen + scfd_pkg::FRAME_OVERHEAD);
        if (flaw == FLAW_BAD_LENGTH) begin
            if ($urandom_range(0, 1) == 0) begin
                len_byte = scfd_pkg::BYTE_W'($urandom_range(0, scfd_pkg::MIN_FRAME - 1));
            end else begin
                len_byte = scfd_pkg::BYTE_W'(
                    $urandom_range(scfd_pkg::MAX_FRAME_DEF + 1, 255));
            end
        end
        stream_q.push_back(head);
        stream_q.push_back(len_byte);
        sum = head + len_byte;
        for (k = 0; k < plen; k++) begin
            value = scfd_pkg::BYTE_W'($urandom);
            stream_q.push_back(value);
            sum += value;
        end
        if (flaw == FLAW_CUT) begin
            repeat ($urandom_range(0, plen)) void'(stream_q.pop_back());
            return;
        end
        if (flaw == FLAW_BAD_SUM) begin
            sum ^= scfd_pkg::BYTE_W'($urandom_range(1, 255));
        end
        stream_q.push_back(sum);
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_byte(input logic [scfd_pkg::BYTE_W-1:0] value);
        int unsigned gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 8);
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= value;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        board.take_byte(value);
        burst_left--;
        @(negedge i_clk);
    endtask

    // A byte can be consumed without any result, so the block gets extra time
    // to finish a rescan before it is treated as idle.
    task automatic drain_block();
        in_ch.valid <= 1'b0;
        while (board.expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_head(input logic [scfd_pkg::BYTE_W-1:0] head);
        drain_block();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= head;
        @(negedge i_clk);
        i_cfg_we        <= 1'b0;
        board.head_byte = head;
        heads_written++;
    endtask

    task automatic send_random_stream(input int unsigned budget);
        int unsigned sent;
        int unsigned pick;
        int unsigned plen;
        t_frame_flaw flaw;
        sent = 0;
        while (sent < budget) begin
            stream_q.delete();
            pick = $urandom_range(0, 15);
            if (pick < 3) begin
                repeat ($urandom_range(1, 6)) begin
                    stream_q.push_back(scfd_pkg::BYTE_W'($urandom));
                end
            end else begin
                if (pick < 11) flaw = FLAW_NONE;
                else if (pick < 13) flaw = FLAW_BAD_SUM;
                else if (pick < 14) flaw = FLAW_BAD_LENGTH;
                else flaw = FLAW_CUT;
                if ($urandom_range(0, 19) == 0) begin
                    plen = $urandom_range(1,
                        scfd_pkg::MAX_FRAME_DEF - scfd_pkg::FRAME_OVERHEAD);
                end else begin
                    plen = $urandom_range(1, 8);
                end
                append_frame(board.head_byte, plen, flaw);
            end
            sent += stream_q.size();
            foreach (stream_q[k]) send_byte(stream_q[k]);
        end
    endtask

    // Receiver: checks beats at the rising edge and sets its ready pattern at
    // the falling edge.
    initial begin
        int unsigned mode_left;
        int unsigned hold_left;
        t_ready_mode mode;
        mode_left = 0;
        hold_left = 0;
        mode      = READY_ALWAYS;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                board.check_beat(out_ch.payload_byte, out_ch.last, out_ch.payload_length);
            end
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_ready_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    READY_ALWAYS: begin
                        out_ch.ready <= 1'b1;
                    end
                    READY_HALF: begin
                        out_ch.ready <= ($urandom_range(0, 1) == 1);
                    end
                    default: begin
                        out_ch.ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    initial begin
        logic [scfd_pkg::BYTE_W-1:0] phase_heads [4];
        board         = new();
        burst_left    = 0;
        heads_written = 0;
        hold_req      = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = '0;
        out_ch.ready  = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under the reset head of zero. The first frame's head
        // waits alone, then gets its length; later ones hit bad lengths on
        // both sides, a bad sum, a payload holding the head value and a sum
        // that wraps to zero.
        stream_q = '{8'h00, 8'h04, 8'hFF, 8'h03,
                     8'h00, 8'h03,
                     8'h00, 8'h41,
                     8'h00, 8'h05, 8'h11, 8'h22, 8'h00,
                     8'h00, 8'h06, 8'h00, 8'hFF, 8'h80, 8'h85,
                     8'h00, 8'h04, 8'hFC, 8'h00};
        foreach (stream_q[k]) send_byte(stream_q[k]);

        phase_heads[0] = 8'hFF;
        phase_heads[1] = scfd_pkg::BYTE_W'($urandom);
        phase_heads[2] = 8'h00;
        phase_heads[3] = scfd_pkg::BYTE_W'($urandom);
        for (int p = 0; p < 4; p++) begin
            write_head(phase_heads[p]);
            if (p == 0) begin
                // Long output hold-off while a full-size frame and more
                // arrive, so the block backs up into its input.
                hold_req = 1'b1;
            end
            if (p % 2 == 0) begin
                stream_q.delete();
                append_frame(board.head_byte,
                             scfd_pkg::MAX_FRAME_DEF - scfd_pkg::FRAME_OVERHEAD, FLAW_NONE);
                foreach (stream_q[k]) send_byte(stream_q[k]);
            end
            send_random_stream(PHASE_ITEMS);
        end
        drain_block();

        $display("Covered %0d stream bytes, %0d payload beats from %0d frames.",
                 board.bytes_taken, board.beats_checked, board.frames_found);
        $display("Frame head written %0d times including both extremes; longest payload %0d.",
                 heads_written, board.longest_payload);
        if (board.error_count == 0 && board.expected_beats.size() == 0) begin
            $display("sum_checked_frame_deframer_top: match");
        end else begin
            $display("sum_checked_frame_deframer_top: mismatch");
        end
        $finish;
    end
endmodule

// ===== sum_checked_frame_deframer_top.f =====
rtl/core/scfd_pkg.sv
rtl/core/scfd_chan_if.sv
rtl/core/scfd_queue.sv
rtl/core/scfd_engine.sv
rtl/core/sum_checked_frame_deframer_top.sv
dv/sum_checked_frame_deframer_top_test.sv
